### sv/arat_pkg.sv
// Shared types, codes and constants for the address region table.
package arat_pkg;

    // Sizes
    localparam int ENTRIES_DEF = 16;
    localparam int MAX_SIZES   = 4;
    localparam int SHIFT_REGS  = 4;
    localparam int SIZE_LIM    = (MAX_SIZES < SHIFT_REGS) ? MAX_SIZES : SHIFT_REGS;
    localparam int ADDR_W      = 64;
    localparam int LEN_W       = 32;
    localparam int SLOT_W      = 4;
    localparam int SHIFT_W     = 6;
    localparam int COUNT_W     = 3;
    localparam int KIW         = $clog2(SHIFT_REGS);
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 6;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_SIZE_COUNT   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SIZE_SHIFT_0 = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SIZE_SHIFT_1 = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SIZE_SHIFT_2 = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SIZE_SHIFT_3 = 3'd4;

    // Configuration reset values
    localparam logic [COUNT_W-1:0] SIZE_COUNT_RST   = 3'd3;
    localparam logic [SHIFT_W-1:0] SIZE_SHIFT_0_RST = 6'd12;
    localparam logic [SHIFT_W-1:0] SIZE_SHIFT_1_RST = 6'd21;
    localparam logic [SHIFT_W-1:0] SIZE_SHIFT_2_RST = 6'd30;
    localparam logic [SHIFT_W-1:0] SIZE_SHIFT_3_RST = 6'd39;

    typedef enum logic [1:0] {
        OP_REGISTER,
        OP_UNREGISTER,
        OP_RANGE,
        OP_PAGE
    } t_op;

    typedef enum logic [1:0] {
        ST_OK,
        ST_OVERLAP,
        ST_FULL,
        ST_NO_SLOT
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SETUP,
        S_SCAN,
        S_WAIT,
        S_EVAL,
        S_FINISH
    } t_state;

    // Store commands for one cycle
    typedef struct packed {
        logic rd;
        logic wr;
        logic clr;
    } t_store_ctl;

    // One table row as read from the store
    typedef struct packed {
        logic              valid;
        logic              live;
        logic [ADDR_W-1:0] base;
        logic [LEN_W-1:0]  len;
    } t_row;

    // Result of the overlap unit for one row
    typedef struct packed {
        logic              valid;
        logic              hit;
        logic              live;
        logic [ADDR_W-1:0] base;
        logic [ADDR_W-1:0] rend;
    } t_hit_res;

endpackage

### sv/arat_store.sv
// Region storage: base/length memory with registered read, live bits in flops.
module arat_store import arat_pkg::*; #(
    parameter int ENTRIES = ENTRIES_DEF,
    localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_store_ctl         i_ctl,
    input  logic [IW-1:0]      i_rd_idx,
    input  logic [IW-1:0]      i_wr_idx,
    input  logic [ADDR_W-1:0]  i_wr_base,
    input  logic [LEN_W-1:0]   i_wr_len,
    output t_row               o_row,
    output logic [ENTRIES-1:0] o_live
);

    logic [ADDR_W-1:0]  mem_base [ENTRIES];
    logic [LEN_W-1:0]   mem_len  [ENTRIES];
    logic [ENTRIES-1:0] r_live;
    logic               r_rd_valid;
    logic               r_rd_live;
    logic [ADDR_W-1:0]  r_rd_base;
    logic [LEN_W-1:0]   r_rd_len;

    // Memory write and registered read
    always_ff @(posedge i_clk) begin
        if (i_ctl.wr) begin
            mem_base[i_wr_idx] <= i_wr_base;
            mem_len[i_wr_idx]  <= i_wr_len;
        end
        if (i_ctl.rd) begin
            r_rd_base <= mem_base[i_rd_idx];
            r_rd_len  <= mem_len[i_rd_idx];
            r_rd_live <= r_live[i_rd_idx];
        end
    end

    // Live bits and read valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_live     <= '0;
            r_rd_valid <= 1'b0;
        end else begin
            r_rd_valid <= i_ctl.rd;
            if (i_ctl.wr) begin
                r_live[i_wr_idx] <= 1'b1;
            end else if (i_ctl.clr) begin
                r_live[i_wr_idx] <= 1'b0;
            end
        end
    end

    assign o_row.valid = r_rd_valid;
    assign o_row.live  = r_rd_live;
    assign o_row.base  = r_rd_base;
    assign o_row.len   = r_rd_len;
    assign o_live      = r_live;

endmodule

### sv/arat_hit.sv
// Shared overlap unit: offset subtract, then limit compares, one row per cycle.
module arat_hit import arat_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_row              i_row,
    input  logic [ADDR_W-1:0] i_start,
    input  logic [ADDR_W-1:0] i_lim,
    output t_hit_res          o_res
);

    logic              r_valid;
    logic              r_live;
    logic [ADDR_W-1:0] r_a;
    logic [ADDR_W-1:0] r_d;
    logic [ADDR_W-1:0] r_base;
    logic [ADDR_W-1:0] r_end;

    // Stage one: offset of the access from the base, last offset inside the row
    always_ff @(posedge i_clk) begin
        r_a    <= i_start - i_row.base;
        r_d    <= ADDR_W'(i_row.len) - ADDR_W'(1);
        r_base <= i_row.base;
        r_end  <= i_row.base + ADDR_W'(i_row.len);
        r_live <= i_row.live;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_row.valid;
        end
    end

    // Stage two: clear of the row when offset is past it and the access does not wrap
    assign o_res.valid = r_valid;
    assign o_res.live  = r_live;
    assign o_res.hit   = r_live && !((r_d < r_a) && (r_a <= i_lim));
    assign o_res.base  = r_base;
    assign o_res.rend  = r_end;

endmodule

### sv/address_region_table.sv
// Address region table top level: sequencer, configuration and result register.
//
//  channel  | handshake                  | payload
//  ---------+----------------------------+---------------------------------------
//  input    | i_in_valid / o_in_stall    | i_operation i_address i_length i_slot
//  result   | o_out_valid / i_out_stall  | o_status o_given_slot o_range_end
//           |                            | o_free_sizes
//  config   | i_cfg_valid / o_cfg_ready  | i_cfg_index i_cfg_data
//
// Register and range query scan every row once through the overlap unit.
// Unregister goes straight to evaluation without a scan; zero-length range query
// and page-size query with no sizes go straight to the finish state. Page-size
// query runs one scan per page size tried. The scan issues one memory read per
// cycle. Reset clears all live bits at once; no clearing pass.
// A finished result waits in the result register while the next beat is taken.
module address_region_table import arat_pkg::*; #(
    parameter int ENTRIES = ENTRIES_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // input items
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic [1:0]            i_operation,
    input  logic [ADDR_W-1:0]     i_address,
    input  logic [LEN_W-1:0]      i_length,
    input  logic [SLOT_W-1:0]     i_slot,
    // results
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic [1:0]            o_status,
    output logic [SLOT_W-1:0]     o_given_slot,
    output logic [ADDR_W-1:0]     o_range_end,
    output logic [COUNT_W-1:0]    o_free_sizes,
    // configuration writes
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam logic [IW-1:0] LAST_IDX = IW'(ENTRIES - 1);

    t_state               r_state, n_state;
    t_store_ctl           st_ctl;
    logic                 scan_start;
    logic                 in_acc;

    // Item registers
    t_op                  r_op;
    logic [ADDR_W-1:0]    r_addr;
    logic [SLOT_W-1:0]    r_slot;
    logic [LEN_W-1:0]     r_len;
    logic [ADDR_W-1:0]    r_start;
    logic [ADDR_W-1:0]    r_lim;
    logic [COUNT_W-1:0]   r_k;
    logic [COUNT_W-1:0]   r_nfree;

    // Scan counters and accumulators
    logic [IW-1:0]        r_iss;
    logic [IW-1:0]        r_rcv;
    logic                 r_any;
    logic                 r_free_found;
    logic [IW-1:0]        r_free;
    logic                 r_best_found;
    logic [ADDR_W-1:0]    r_best_base;
    logic [ADDR_W-1:0]    r_best_end;

    // Pending result
    t_status              r_st;
    logic [SLOT_W-1:0]    r_gs;
    logic [ADDR_W-1:0]    r_re;

    // Result register
    logic                 r_out_valid;
    t_status              r_out_status;
    logic [SLOT_W-1:0]    r_out_slot;
    logic [ADDR_W-1:0]    r_out_end;
    logic [COUNT_W-1:0]   r_out_free;

    // Configuration
    logic [COUNT_W-1:0]   r_size_count;
    logic [SHIFT_W-1:0]   r_shift [SHIFT_REGS];

    t_row                 row;
    t_hit_res             hit_res;
    logic [ENTRIES-1:0]   live;
    logic [IW-1:0]        wr_idx;
    logic [COUNT_W-1:0]   n_eff;
    logic [ADDR_W-1:0]    page_mask;
    logic                 slot_ok;
    logic                 out_free;

    assign in_acc     = i_in_valid && (r_state == S_IDLE);
    assign o_in_stall = (r_state != S_IDLE);
    assign out_free   = !r_out_valid || !i_out_stall;
    assign n_eff      = (r_size_count > COUNT_W'(SIZE_LIM)) ? COUNT_W'(SIZE_LIM) : r_size_count;
    assign page_mask  = {ADDR_W{1'b1}} << r_shift[r_k[KIW-1:0]];
    assign slot_ok    = (32'(r_slot) < ENTRIES) && live[IW'(r_slot)];
    assign wr_idx     = (r_op == OP_UNREGISTER) ? IW'(r_slot) : r_free;

    arat_store #(
        .ENTRIES   (ENTRIES)
    ) u_store (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (st_ctl),
        .i_rd_idx  (r_iss),
        .i_wr_idx  (wr_idx),
        .i_wr_base (r_addr),
        .i_wr_len  (r_len),
        .o_row     (row),
        .o_live    (live)
    );

    arat_hit u_hit (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_row     (row),
        .i_start   (r_start),
        .i_lim     (r_lim),
        .o_res     (hit_res)
    );

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Sequencer: next state and store commands
    always_comb begin
        n_state    = r_state;
        st_ctl     = '0;
        scan_start = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    unique case (t_op'(i_operation))
                        OP_REGISTER: begin
                            n_state    = S_SCAN;
                            scan_start = 1'b1;
                        end
                        OP_UNREGISTER: begin
                            n_state = S_EVAL;
                        end
                        OP_RANGE: begin
                            if (i_length != '0) begin
                                n_state    = S_SCAN;
                                scan_start = 1'b1;
                            end else begin
                                n_state = S_FINISH;
                            end
                        end
                        OP_PAGE: begin
                            n_state = (n_eff == '0) ? S_FINISH : S_SETUP;
                        end
                        default: n_state = S_IDLE;
                    endcase
                end
            end
            S_SETUP: begin
                n_state    = S_SCAN;
                scan_start = 1'b1;
            end
            S_SCAN: begin
                st_ctl.rd = 1'b1;
                if (r_iss == LAST_IDX) begin
                    n_state = S_WAIT;
                end
            end
            S_WAIT: begin
                if (hit_res.valid && (r_rcv == LAST_IDX)) begin
                    n_state = S_EVAL;
                end
            end
            S_EVAL: begin
                n_state = S_FINISH;
                unique case (r_op)
                    OP_REGISTER: begin
                        st_ctl.wr = !r_any && r_free_found;
                    end
                    OP_UNREGISTER: begin
                        st_ctl.clr = slot_ok;
                    end
                    OP_PAGE: begin
                        if (!r_any && ((r_k + COUNT_W'(1)) < n_eff)) begin
                            n_state = S_SETUP;
                        end
                    end
                    default: n_state = S_FINISH;
                endcase
            end
            S_FINISH: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Item capture, scan bookkeeping and result build
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_op    <= t_op'(i_operation);
            r_addr  <= i_address;
            r_len   <= i_length;
            r_slot  <= i_slot;
            r_start <= i_address;
            r_lim   <= ~(ADDR_W'(i_length) - ADDR_W'(1));
            r_k     <= '0;
            r_nfree <= '0;
            r_st    <= ST_OK;
            r_gs    <= '0;
            r_re    <= '0;
        end

        // Aligned block for the current page size
        if (r_state == S_SETUP) begin
            r_start <= r_addr & page_mask;
            r_lim   <= page_mask;
        end

        if (scan_start) begin
            r_iss        <= '0;
            r_rcv        <= '0;
            r_any        <= 1'b0;
            r_free_found <= 1'b0;
            r_free       <= '0;
            r_best_found <= 1'b0;
            r_best_base  <= '0;
            r_best_end   <= '0;
        end else begin
            if ((r_state == S_SCAN) && (r_iss != LAST_IDX)) begin
                r_iss <= r_iss + IW'(1);
            end
            // Fold in one row result, rows arrive in index order
            if (hit_res.valid) begin
                if (r_rcv != LAST_IDX) begin
                    r_rcv <= r_rcv + IW'(1);
                end
                if (hit_res.hit) begin
                    r_any <= 1'b1;
                    if (!r_best_found || (hit_res.base < r_best_base)) begin
                        r_best_found <= 1'b1;
                        r_best_base  <= hit_res.base;
                        r_best_end   <= hit_res.rend;
                    end
                end
                if (!hit_res.live && !r_free_found) begin
                    r_free_found <= 1'b1;
                    r_free       <= r_rcv;
                end
            end
        end

        if (r_state == S_EVAL) begin
            case (r_op)
                OP_REGISTER: begin
                    if (r_any) begin
                        r_st <= ST_OVERLAP;
                    end else if (!r_free_found) begin
                        r_st <= ST_FULL;
                    end else begin
                        r_gs <= SLOT_W'(r_free);
                    end
                end
                OP_UNREGISTER: begin
                    if (!slot_ok) begin
                        r_st <= ST_NO_SLOT;
                    end
                end
                OP_RANGE: begin
                    r_re <= r_best_end;
                end
                default: begin
                    if (!r_any) begin
                        r_nfree <= r_nfree + COUNT_W'(1);
                        r_k     <= r_k + COUNT_W'(1);
                    end
                end
            endcase
        end

        // Result payload
        if ((r_state == S_FINISH) && out_free) begin
            r_out_status <= r_st;
            r_out_slot   <= r_gs;
            r_out_end    <= r_re;
            r_out_free   <= r_nfree;
        end
    end

    // Result valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if ((r_state == S_FINISH) && out_free) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size_count <= SIZE_COUNT_RST;
            r_shift[0]   <= SIZE_SHIFT_0_RST;
            r_shift[1]   <= SIZE_SHIFT_1_RST;
            r_shift[2]   <= SIZE_SHIFT_2_RST;
            r_shift[3]   <= SIZE_SHIFT_3_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_SIZE_COUNT:   r_size_count <= i_cfg_data[COUNT_W-1:0];
                REG_SIZE_SHIFT_0: r_shift[0]   <= i_cfg_data;
                REG_SIZE_SHIFT_1: r_shift[1]   <= i_cfg_data;
                REG_SIZE_SHIFT_2: r_shift[2]   <= i_cfg_data;
                REG_SIZE_SHIFT_3: r_shift[3]   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign o_cfg_ready  = 1'b1;
    assign o_out_valid  = r_out_valid;
    assign o_status     = r_out_status;
    assign o_given_slot = r_out_slot;
    assign o_range_end  = r_out_end;
    assign o_free_sizes = r_out_free;

    // Checks
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input taken again right after a beat");

    a_rows_only_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        hit_res.valid |-> (r_state == S_SCAN || r_state == S_WAIT))
        else $error("row result outside a scan");

    a_write_free_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        st_ctl.wr |-> !live[r_free])
        else $error("register overwrites a live entry");

    a_free_sizes_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_free_sizes <= COUNT_W'(SIZE_LIM)))
        else $error("free size count out of range");

endmodule

### bench/address_region_table_tb.sv
// Testbench for the address region table: random and directed traffic against a predictor.
`timescale 1ns / 1ps

module address_region_table_tb;
    import arat_pkg::*;

    localparam int SLOTS          = 16;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 100;
    // Index past the last size register; the block ignores writes to it
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd5;

    // One result beat as the predictor expects it
    typedef struct packed {
        t_status              status;
        logic [SLOT_W-1:0]    given_slot;
        logic [ADDR_W-1:0]    range_end;
        logic [COUNT_W-1:0]   free_sizes;
    } t_table_answer;

    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  i_in_valid  = 1'b0;
    logic                  o_in_stall;
    logic [1:0]            i_operation = '0;
    logic [ADDR_W-1:0]     i_address   = '0;
    logic [LEN_W-1:0]      i_length    = '0;
    logic [SLOT_W-1:0]     i_slot      = '0;
    logic                  o_out_valid;
    logic                  i_out_stall = 1'b0;
    logic [1:0]            o_status;
    logic [SLOT_W-1:0]     o_given_slot;
    logic [ADDR_W-1:0]     o_range_end;
    logic [COUNT_W-1:0]    o_free_sizes;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data  = '0;

    // Predictor copy of the table and the size registers
    logic                 slot_live [SLOTS];
    logic [ADDR_W-1:0]    slot_base [SLOTS];
    logic [LEN_W-1:0]     slot_len  [SLOTS];
    logic [COUNT_W-1:0]   cfg_count;
    logic [SHIFT_W-1:0]   cfg_shift [SHIFT_REGS];

    t_table_answer answers_due[$];

    int  errors          = 0;
    int  items_sent      = 0;
    int  results_checked = 0;
    int  cfg_writes      = 0;
    int  idle_cycles     = 0;
    int  stall_left      = 0;
    logic pace_on        = 1'b1;

    address_region_table uut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_operation  (i_operation),
        .i_address    (i_address),
        .i_length     (i_length),
        .i_slot       (i_slot),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_status     (o_status),
        .o_given_slot (o_given_slot),
        .o_range_end  (o_range_end),
        .o_free_sizes (o_free_sizes),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // Modulo-2^64 offset test: no overlap only when d < a and a <= b
    function automatic logic region_hits(int k, logic [ADDR_W-1:0] start,
                                         logic [ADDR_W-1:0] span);
        logic [ADDR_W-1:0] a, b, d;
        a = start - slot_base[k];
        b = start + span - 64'd1 - slot_base[k];
        d = {32'd0, slot_len[k]} - 64'd1;
        if (!slot_live[k])
            return 1'b0;
        return !(d < a && a <= b);
    endfunction

    function automatic logic block_taken(logic [ADDR_W-1:0] start, logic [ADDR_W-1:0] span);
        for (int k = 0; k < SLOTS; k++)
            if (region_hits(k, start, span))
                return 1'b1;
        return 1'b0;
    endfunction

    // Works out the answer to one request and updates the table copy
    function automatic t_table_answer table_answer(t_op op, logic [ADDR_W-1:0] addr,
                                                   logic [LEN_W-1:0] len,
                                                   logic [SLOT_W-1:0] slot);
        t_table_answer     ans;
        logic              found;
        logic [ADDR_W-1:0] best, psize, pstart;
        int                k, n;
        ans = '0;
        ans.status = ST_OK;
        case (op)
            OP_REGISTER: begin
                // overlap is checked before the full test
                if (block_taken(addr, {32'd0, len})) begin
                    ans.status = ST_OVERLAP;
                end else begin
                    k = 0;
                    while (k < SLOTS && slot_live[k])
                        k++;
                    if (k >= SLOTS) begin
                        ans.status = ST_FULL;
                    end else begin
                        slot_live[k]   = 1'b1;
                        slot_base[k]   = addr;
                        slot_len[k]    = len;
                        ans.given_slot = 4'(k);
                    end
                end
            end
            OP_UNREGISTER: begin
                if (slot_live[slot])
                    slot_live[slot] = 1'b0;
                else
                    ans.status = ST_NO_SLOT;
            end
            OP_RANGE: begin
                // zero-length access answers 0; lowest base wins, first slot on a tie
                if (len != 0) begin
                    found = 1'b0;
                    best  = '0;
                    for (k = 0; k < SLOTS; k++) begin
                        if (region_hits(k, addr, {32'd0, len}) &&
                            (!found || slot_base[k] < best)) begin
                            found         = 1'b1;
                            best          = slot_base[k];
                            ans.range_end = slot_base[k] + {32'd0, slot_len[k]};
                        end
                    end
                end
            end
            default: begin
                // count saturates at the number of size registers
                n = int'(cfg_count);
                if (n > SIZE_LIM)
                    n = SIZE_LIM;
                for (k = 0; k < n; k++) begin
                    psize  = 64'd1 << cfg_shift[k];
                    pstart = addr & ~(psize - 64'd1);
                    if (block_taken(pstart, psize))
                        break;
                    ans.free_sizes = ans.free_sizes + 3'd1;
                end
            end
        endcase
        return ans;
    endfunction

    // ------------------------------------------------------------------
    // Random helpers
    // ------------------------------------------------------------------

    // Mostly no pause, some short, a few long
    function automatic int pick_pause();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(6, 40);
    endfunction

    function automatic logic [ADDR_W-1:0] rand_addr();
        logic [ADDR_W-1:0] a;
        int                k;
        k = $urandom_range(0, SLOTS - 1);
        case ($urandom_range(0, 9))
            0, 1, 2, 3: a = 64'($urandom_range(0, 32'h000F_FFFF));
            4:          a = 64'h0000_7F00_0000_0000 | 64'($urandom_range(0, 32'h000F_FFFF));
            5:          a = {$urandom, $urandom};
            6:          a = slot_base[k] + 64'($urandom_range(0, 64)) - 64'd32;
            7:          a = slot_base[k] + {32'd0, slot_len[k]} - 64'($urandom_range(0, 2));
            8:          a = {$urandom, $urandom} & ~((64'd1 << $urandom_range(0, 40)) - 64'd1);
            default:    a = 64'hFFFF_FFFF_FFFF_FFFF - 64'($urandom_range(0, 32'h000F_FFFF));
        endcase
        return a;
    endfunction

    function automatic logic [LEN_W-1:0] rand_len();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return 32'hFFFF_FFFF;
            2:       return $urandom;
            3:       return 32'd1;
            default: return $urandom_range(1, 32'h4000);
        endcase
    endfunction

    function automatic logic [SLOT_W-1:0] pick_live_slot(logic [SLOT_W-1:0] fallback);
        int first, k;
        first = $urandom_range(0, SLOTS - 1);
        for (int j = 0; j < SLOTS; j++) begin
            k = (first + j) % SLOTS;
            if (slot_live[k])
                return 4'(k);
        end
        return fallback;
    endfunction

    // ------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------

    // Sends one request beat; entered and left at a falling edge with valid held
    task automatic send_request(t_op op, logic [ADDR_W-1:0] addr,
                                logic [LEN_W-1:0] len, logic [SLOT_W-1:0] slot);
        int gap;
        gap = pace_on ? pick_pause() : 0;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_operation <= op;
        i_address   <= addr;
        i_length    <= len;
        i_slot      <= slot;
        i_in_valid  <= 1'b1;
        do @(posedge i_clk); while (o_in_stall);
        answers_due.push_back(table_answer(op, addr, len, slot));
        items_sent++;
        @(negedge i_clk);
    endtask

    // Drops valid and waits until every outstanding result has come back
    task automatic wait_idle();
        i_in_valid <= 1'b0;
        while (answers_due.size() != 0)
            @(negedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] index, logic [CFG_DATA_W-1:0] data);
        i_cfg_index <= index;
        i_cfg_data  <= data;
        i_cfg_valid <= 1'b1;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (index)
            REG_SIZE_COUNT:   cfg_count    = data[COUNT_W-1:0];
            REG_SIZE_SHIFT_0: cfg_shift[0] = data;
            REG_SIZE_SHIFT_1: cfg_shift[1] = data;
            REG_SIZE_SHIFT_2: cfg_shift[2] = data;
            REG_SIZE_SHIFT_3: cfg_shift[3] = data;
            default: ;
        endcase
        cfg_writes++;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic apply_sizes(logic [CFG_DATA_W-1:0] count_data,
                               logic [SHIFT_W-1:0] s0, logic [SHIFT_W-1:0] s1,
                               logic [SHIFT_W-1:0] s2, logic [SHIFT_W-1:0] s3);
        wait_idle();
        write_reg(REG_SIZE_COUNT, count_data);
        write_reg(REG_SIZE_SHIFT_0, s0);
        write_reg(REG_SIZE_SHIFT_1, s1);
        write_reg(REG_SIZE_SHIFT_2, s2);
        write_reg(REG_SIZE_SHIFT_3, s3);
    endtask

    // Random table traffic; page_pct is the share of page-size queries
    task automatic run_traffic(int count, int page_pct);
        t_op               op;
        logic [ADDR_W-1:0] addr;
        logic [LEN_W-1:0]  len;
        logic [SLOT_W-1:0] slot;
        int                r;
        for (int i = 0; i < count; i++) begin
            addr = rand_addr();
            len  = rand_len();
            slot = 4'($urandom_range(0, SLOTS - 1));
            r    = $urandom_range(0, 99);
            if (r < page_pct) begin
                op = OP_PAGE;
            end else begin
                r = $urandom_range(0, 99);
                if (r < 45) begin
                    op = OP_REGISTER;
                end else if (r < 68) begin
                    op = OP_UNREGISTER;
                    // mostly free a live slot, sometimes a random one
                    if ($urandom_range(0, 3) != 0)
                        slot = pick_live_slot(slot);
                end else begin
                    op = OP_RANGE;
                end
            end
            send_request(op, addr, len, slot);
        end
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Field extremes, every operation and the corner cases, reset sizes
    task automatic test_directed_ops();
        send_request(OP_RANGE, 64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF, 4'd0);
        send_request(OP_PAGE, 64'h0, 32'd0, 4'd0);
        send_request(OP_REGISTER, 64'h1000, 32'h1000, 4'd0);
        send_request(OP_REGISTER, 64'h1800, 32'h10, 4'd0);
        send_request(OP_RANGE, 64'h1FFF, 32'd1, 4'd0);
        send_request(OP_RANGE, 64'h2000, 32'd1, 4'd0);
        // region ending exactly at the top; its end wraps to zero
        send_request(OP_REGISTER, 64'hFFFF_FFFF_FFFF_FF00, 32'h100, 4'd0);
        send_request(OP_RANGE, 64'hFFFF_FFFF_FFFF_FFFF, 32'd1, 4'd0);
        send_request(OP_REGISTER, 64'h0001_0000_0000_0000, 32'hFFFF_FFFF, 4'd0);
        send_request(OP_PAGE, 64'h1234, 32'd0, 4'd0);
        send_request(OP_PAGE, 64'h0001_0001_0000_0000, 32'd0, 4'd0);
        send_request(OP_RANGE, 64'h1000, 32'd0, 4'd0);
        // free a live slot, then the same slot again, then one never used
        send_request(OP_UNREGISTER, 64'h0, 32'd0, 4'd1);
        send_request(OP_UNREGISTER, 64'h0, 32'd0, 4'd1);
        send_request(OP_UNREGISTER, 64'h0, 32'd0, 4'd15);
        // zero-length region against a non-empty table
        send_request(OP_REGISTER, 64'h5000, 32'd0, 4'd0);
        send_request(OP_RANGE, 64'h0, 32'hFFFF_FFFF, 4'd0);
        send_request(OP_UNREGISTER, 64'h0, 32'd0, 4'd0);
        send_request(OP_UNREGISTER, 64'h0, 32'd0, 4'd2);
        // zero-length region on an empty table overlaps every later access
        send_request(OP_REGISTER, 64'h5000, 32'd0, 4'd0);
        send_request(OP_RANGE, 64'hDEAD_0000, 32'd4, 4'd0);
        send_request(OP_PAGE, 64'h0, 32'd0, 4'd0);
        send_request(OP_UNREGISTER, 64'h0, 32'd0, 4'd0);
        send_request(OP_RANGE, 64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF, 4'd15);
    endtask

    task automatic test_mixed_traffic();
        pace_on = 1'b1;
        run_traffic(300, 15);
    endtask

    // Page-size query under several size settings, extremes included
    task automatic test_page_settings();
        apply_sizes(6'd4, 6'd0, 6'd1, 6'd2, 6'd3);
        run_traffic(80, 50);
        apply_sizes(6'd0, 6'd12, 6'd21, 6'd30, 6'd39);
        run_traffic(80, 50);
        // count above the limit saturates; shifts out of order
        apply_sizes(6'h3F, 6'd63, 6'd62, 6'd40, 6'd20);
        run_traffic(80, 50);
        apply_sizes(6'd1, 6'd63, 6'd0, 6'd0, 6'd0);
        run_traffic(80, 50);
        apply_sizes(6'd2, 6'd12, 6'd16, 6'd63, 6'd0);
        run_traffic(80, 50);
        wait_idle();
        write_reg(REG_UNUSED, 6'h2A);
        apply_sizes(6'(SIZE_COUNT_RST), SIZE_SHIFT_0_RST, SIZE_SHIFT_1_RST,
                    SIZE_SHIFT_2_RST, SIZE_SHIFT_3_RST);
        run_traffic(80, 50);
    endtask

    // No gaps and no stalls: beats back to back
    task automatic test_back_to_back();
        pace_on = 1'b0;
        run_traffic(60, 25);
        pace_on = 1'b1;
    endtask

    // ------------------------------------------------------------------
    // Result side: random stall, checker and activity count
    // ------------------------------------------------------------------

    always @(negedge i_clk) begin
        if (!pace_on) begin
            i_out_stall <= 1'b0;
        end else if (stall_left > 0) begin
            i_out_stall <= 1'b1;
            stall_left  = stall_left - 1;
        end else begin
            stall_left = pick_pause();
            if (stall_left > 0) begin
                i_out_stall <= 1'b1;
                stall_left  = stall_left - 1;
            end else begin
                i_out_stall <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin : check_results
        t_table_answer want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (answers_due.size() == 0) begin
                $error("result beat with no request outstanding");
                errors++;
            end else begin
                want = answers_due.pop_front();
                results_checked++;
                if (o_status !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, o_status);
                    errors++;
                end
                if (o_given_slot !== want.given_slot) begin
                    $error("given_slot: expected %0d, got %0d", want.given_slot, o_given_slot);
                    errors++;
                end
                if (o_range_end !== want.range_end) begin
                    $error("range_end: expected %h, got %h", want.range_end, o_range_end);
                    errors++;
                end
                if (o_free_sizes !== want.free_sizes) begin
                    $error("free_sizes: expected %0d, got %0d", want.free_sizes, o_free_sizes);
                    errors++;
                end
            end
        end
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) ||
            (i_cfg_valid && o_cfg_ready))
            idle_cycles = 0;
        else
            idle_cycles = idle_cycles + 1;
    end

    // Watchdog on cycles with no beat moving
    initial begin : watchdog
        while (idle_cycles < WATCHDOG_LIMIT)
            @(posedge i_clk);
        $display("timeout: no beat for %0d cycles", WATCHDOG_LIMIT);
        $display("== FAIL ==");
        $finish;
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------

    initial begin : main_seq
        for (int k = 0; k < SLOTS; k++) begin
            slot_live[k] = 1'b0;
            slot_base[k] = '0;
            slot_len[k]  = '0;
        end
        cfg_count    = SIZE_COUNT_RST;
        cfg_shift[0] = SIZE_SHIFT_0_RST;
        cfg_shift[1] = SIZE_SHIFT_1_RST;
        cfg_shift[2] = SIZE_SHIFT_2_RST;
        cfg_shift[3] = SIZE_SHIFT_3_RST;

        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_directed_ops();
        test_mixed_traffic();
        test_page_settings();
        test_back_to_back();

        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Sent %0d table requests, checked %0d results, %0d register writes.",
                 items_sent, results_checked, cfg_writes);
        $display("Covered register/unregister/range/page-size traffic under six size settings.");
        if (errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
